// ----- rtl/core/lnfs_pkg.sv -----
// lnfs_pkg: shared types and constants for the laplace noise sampler
// used by every module under rtl/core; no dependencies
`default_nettype none

package lnfs_pkg;

    localparam int SHARE_W       = 32;
    localparam int K_W           = 24;
    localparam int X_W           = 32;
    localparam int E_W           = 5;
    localparam int LOG_FRAC_BITS = 28;
    localparam int M_W           = 33;
    localparam int LN_W          = 37;
    localparam int SCALE_W       = 24;
    localparam int NOISE_W       = 32;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
    localparam logic [29:0]        LN2_Q30     = 30'd744261118;
    localparam logic [E_W-1:0]     LOG_OFFSET  = 5'd24;

    typedef struct packed {
        logic           positive;
        logic           zero;
        logic [E_W-1:0] expo;
    } lnfs_meta_t;

    typedef struct packed {
        logic [X_W-1:0]           x;
        logic [LOG_FRAC_BITS-1:0] frac;
        lnfs_meta_t               meta;
    } lnfs_sq_t;

endpackage

`default_nettype wire

// ----- rtl/core/laplace_noise_from_shares.sv -----
// laplace_noise_from_shares: top level, front stages, squaring cell chain,
// back stages and output skid; depends on lnfs_pkg, lnfs_front, lnfs_cell, lnfs_back
//
// usage:
//   s_ channel: one transfer carries two 32-bit random shares
//     (s_tdata[31:0] share_a, s_tdata[63:32] share_b)
//   m_ channel: one transfer per input item, in order; m_tdata holds the
//     noise sample in signed q16.16 (FRACTION_BITS fraction bits), m_tuser
//     is set when the uniform value was zero and the sample saturated
//   cfg_wr_en / cfg_wr_data load the 24-bit unsigned q8.16 scale; write it
//     only while no items are in flight
//   latency: 37 cycles from an s_ transfer to m_tvalid, set by the two
//     front stages, 28 squaring cells (one log2 fraction bit each), six
//     back stages and the output register
//   throughput: one item per cycle
//   reset: clears all valid bits, empties the pipeline, scale returns to 1.0
//   stall: while m_tready is low one more result goes to a skid register;
//     s_tready then drops and the whole pipeline holds until it drains
`default_nettype none

module laplace_noise_from_shares #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [23:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // share_a [31:0], share_b [63:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // noise [31:0]
    output logic [0:0]       m_tuser    // log_of_zero [0]
);
    import lnfs_pkg::*;

    logic                pipe_en;
    logic [SCALE_W-1:0]  scale_reg;
    logic                chain_valid [LOG_FRAC_BITS+1];
    lnfs_sq_t            chain_sq    [LOG_FRAC_BITS+1];
    logic                tail_valid;
    logic [NOISE_W-1:0]  tail_noise;
    logic                tail_zero;
    logic                out_valid_reg;
    logic [NOISE_W-1:0]  out_noise_reg;
    logic                out_zero_reg;
    logic                skid_valid_reg;
    logic [NOISE_W-1:0]  skid_noise_reg;
    logic                skid_zero_reg;
    logic                out_free;

    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
        end else if (cfg_wr_en) begin
            scale_reg <= cfg_wr_data;
        end
    end

    lnfs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (pipe_en),
        .in_valid   (s_tvalid),
        .in_share_a (s_tdata[31:0]),
        .in_share_b (s_tdata[63:32]),
        .out_valid  (chain_valid[0]),
        .out_sq     (chain_sq[0])
    );

    for (genvar g = 0; g < LOG_FRAC_BITS; g++) begin : g_cell
        lnfs_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (chain_valid[g]),
            .in_sq     (chain_sq[g]),
            .out_valid (chain_valid[g+1]),
            .out_sq    (chain_sq[g+1])
        );
    end

    lnfs_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (chain_valid[LOG_FRAC_BITS]),
        .in_sq     (chain_sq[LOG_FRAC_BITS]),
        .scale     (scale_reg),
        .out_valid (tail_valid),
        .out_noise (tail_noise),
        .out_zero  (tail_zero)
    );

    // output register with skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_free) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (tail_valid) begin
            if (out_free) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_free) begin
                out_noise_reg <= skid_noise_reg;
                out_zero_reg  <= skid_zero_reg;
            end
        end else if (tail_valid) begin
            if (out_free) begin
                out_noise_reg <= tail_noise;
                out_zero_reg  <= tail_zero;
            end else begin
                skid_noise_reg <= tail_noise;
                skid_zero_reg  <= tail_zero;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_noise_reg;
    assign m_tuser[0] = out_zero_reg;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid filled without an output stall");

    a_zero_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata == 32'h80000000 || m_tdata == 32'h7fffffff))
        else $error("log of zero flagged on an unsaturated sample");

    a_hold_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("skid result dropped during a stall");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/lnfs_cell.sv -----
// lnfs_cell: one squaring cell of the log2 chain, yields one fraction bit
// depends on lnfs_pkg
`default_nettype none

module lnfs_cell (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire lnfs_pkg::lnfs_sq_t in_sq,
    output logic                  out_valid,
    output lnfs_pkg::lnfs_sq_t    out_sq
);
    import lnfs_pkg::*;

    logic [2*X_W-1:0] square;
    logic [X_W:0]     scaled;
    logic             bit_set;
    lnfs_sq_t         sq_next;
    logic             valid_reg;
    lnfs_sq_t         sq_reg;

    always_comb begin
        square  = {{X_W{1'b0}}, in_sq.x} * {{X_W{1'b0}}, in_sq.x};
        scaled  = square[2*X_W-1:X_W-1];
        bit_set = scaled[X_W];
        sq_next      = in_sq;
        sq_next.x    = bit_set ? scaled[X_W:1] : scaled[X_W-1:0];
        sq_next.frac = {in_sq.frac[LOG_FRAC_BITS-2:0], bit_set};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= sq_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_sq    = sq_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lnfs_front.sv -----
// lnfs_front: share combine, sign, uniform index and normalization stages
// depends on lnfs_pkg
`default_nettype none

module lnfs_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [lnfs_pkg::SHARE_W-1:0]  in_share_a,
    input  wire logic [lnfs_pkg::SHARE_W-1:0]  in_share_b,
    output logic                               out_valid,
    output lnfs_pkg::lnfs_sq_t                 out_sq
);
    import lnfs_pkg::*;

    logic [SHARE_W-1:0] seed;
    logic [SHARE_W-1:0] absval;
    logic               pos_next;
    logic [K_W-1:0]     k_next;
    logic               v1_reg;
    logic               pos1_reg;
    logic [K_W-1:0]     k1_reg;
    logic [E_W-1:0]     expo;
    lnfs_sq_t           sq_next;
    logic               v2_reg;
    lnfs_sq_t           sq_reg;

    // stage 1: seed, sign and uniform index
    always_comb begin
        seed     = in_share_a ^ in_share_b;
        pos_next = (seed != '0) && !seed[SHARE_W-1];
        absval   = pos_next ? seed : (SHARE_W'(0) - seed);
        k_next   = {absval[0], absval[K_W-2:0]};
    end

    // stage 2: leading one and normalization to q1.31
    always_comb begin
        expo = '0;
        for (int i = 0; i < K_W; i++) begin
            if (k1_reg[i]) begin
                expo = E_W'(i);
            end
        end
        sq_next.x             = X_W'(k1_reg) << (E_W'(X_W - 1) - expo);
        sq_next.frac          = '0;
        sq_next.meta.positive = pos1_reg;
        sq_next.meta.zero     = (k1_reg == '0);
        sq_next.meta.expo     = expo;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos1_reg <= pos_next;
            k1_reg   <= k_next;
            sq_reg   <= sq_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_sq    = sq_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lnfs_back.sv -----
// lnfs_back: log2 to ln conversion, scale multiply, rounding and saturation
// depends on lnfs_pkg
`default_nettype none

module lnfs_back #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire lnfs_pkg::lnfs_sq_t            in_sq,
    input  wire logic [lnfs_pkg::SCALE_W-1:0]  scale,
    output logic                               out_valid,
    output logic [lnfs_pkg::NOISE_W-1:0]       out_noise,
    output logic                               out_zero
);
    import lnfs_pkg::*;

    localparam int SH    = 48 - FRACTION_BITS;
    localparam int PR_W  = LN_W + SCALE_W + 1;
    localparam int MAG_W = PR_W - SH;
    localparam int CMP_W = (MAG_W > 33) ? MAG_W : 33;
    localparam int LN_SUM_W = M_W + 30;
    localparam logic [PR_W-1:0]     MAG_ROUND = PR_W'(1) << (SH - 1);
    localparam logic [LN_SUM_W-1:0] LN_ROUND  = LN_SUM_W'(1) << 25;
    localparam logic [CMP_W-1:0]    NEG_MAX   = CMP_W'(33'h080000000);
    localparam logic [CMP_W-1:0]    POS_MAX   = CMP_W'(33'h07fffffff);

    logic [5:0]          v_reg;
    logic [4:0]          pos_reg;
    logic [5:0]          zero_reg;

    logic [M_W-1:0]      m_next;
    logic [M_W-1:0]      m_reg;
    logic [46:0]         lnhi_next;
    logic [45:0]         lnlo_next;
    logic [46:0]         lnhi_reg;
    logic [45:0]         lnlo_reg;
    logic [LN_SUM_W-1:0] ln_sum;
    logic [LN_W-1:0]     ln_reg;
    logic [42:0]         phi_next;
    logic [41:0]         plo_next;
    logic [42:0]         phi_reg;
    logic [41:0]         plo_reg;
    logic [PR_W-1:0]     pr_sum;
    logic [MAG_W-1:0]    mag_reg;
    logic [CMP_W-1:0]    mag_ext;
    logic [NOISE_W-1:0]  noise_next;
    logic [NOISE_W-1:0]  noise_reg;

    always_comb begin
        m_next = {(LOG_OFFSET - in_sq.meta.expo), {LOG_FRAC_BITS{1'b0}}}
               - {{E_W{1'b0}}, in_sq.frac};
        lnhi_next = {30'd0, m_reg[M_W-1:16]} * {17'd0, LN2_Q30};
        lnlo_next = {30'd0, m_reg[15:0]} * {16'd0, LN2_Q30};
        ln_sum = {lnhi_reg, 16'd0} + {{(LN_SUM_W-46){1'b0}}, lnlo_reg} + LN_ROUND;
        phi_next = {24'd0, ln_reg[LN_W-1:18]} * {19'd0, scale};
        plo_next = {24'd0, ln_reg[17:0]} * {18'd0, scale};
        pr_sum = {1'b0, phi_reg, 18'd0} + {{(PR_W-42){1'b0}}, plo_reg} + MAG_ROUND;
        mag_ext = CMP_W'(mag_reg);
        if (zero_reg[4]) begin
            noise_next = pos_reg[4] ? 32'h80000000 : 32'h7fffffff;
        end else if (pos_reg[4]) begin
            noise_next = (mag_ext > NEG_MAX) ? 32'h80000000
                                             : (32'd0 - mag_ext[NOISE_W-1:0]);
        end else begin
            noise_next = (mag_ext > POS_MAX) ? 32'h7fffffff : mag_ext[NOISE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg  <= {pos_reg[3:0], in_sq.meta.positive};
            zero_reg <= {zero_reg[4:0], in_sq.meta.zero};
            m_reg     <= m_next;
            lnhi_reg  <= lnhi_next;
            lnlo_reg  <= lnlo_next;
            ln_reg    <= ln_sum[LN_SUM_W-1:26];
            phi_reg   <= phi_next;
            plo_reg   <= plo_next;
            mag_reg   <= pr_sum[PR_W-1:SH];
            noise_reg <= noise_next;
        end
    end

    assign out_valid = v_reg[5];
    assign out_noise = noise_reg;
    assign out_zero  = zero_reg[5];

endmodule

`default_nettype wire
